@@ src/gbsp_pkg.sv @@
// Package: shared types, codes and constants of the GIF block stream parser.
package gbsp_pkg;

  localparam logic [2:0] KIND_SCREEN  = 3'd0;
  localparam logic [2:0] KIND_PALETTE = 3'd1;
  localparam logic [2:0] KIND_CONTROL = 3'd2;
  localparam logic [2:0] KIND_LOOP    = 3'd3;
  localparam logic [2:0] KIND_IMAGE   = 3'd4;
  localparam logic [2:0] KIND_TRAILER = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_RESUME = 1'b1;

  localparam logic [7:0] BLK_TRAILER = 8'h3B;
  localparam logic [7:0] BLK_EXT     = 8'h21;
  localparam logic [7:0] BLK_IMAGE   = 8'h2C;
  localparam logic [7:0] EXT_CONTROL = 8'hF9;
  localparam logic [7:0] EXT_APP     = 8'hFF;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] word_value;
    logic [15:0] height;
    logic [7:0]  index_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  aspect_ratio;
    logic [3:0]  color_bits;
    logic [3:0]  color_resolution;
    logic [5:0]  flags;
    logic [2:0]  disposal;
  } result_t;

  function automatic logic [7:0] gif_magic(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0: c = 8'h47;
      2'd1: c = 8'h49;
      2'd2: c = 8'h46;
      default: c = 8'h38;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] app_name(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = 8'h4E;
      4'd1: c = 8'h45;
      4'd2: c = 8'h54;
      4'd3: c = 8'h53;
      4'd4: c = 8'h43;
      4'd5: c = 8'h41;
      4'd6: c = 8'h50;
      4'd7: c = 8'h45;
      4'd8: c = 8'h32;
      4'd9: c = 8'h2E;
      4'd10: c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ src/gbsp_in_if.sv @@
// Interface: input item channel (valid/ready with op and data byte).
interface gbsp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  modport source (output valid, op, data_byte, input ready);
  modport sink (input valid, op, data_byte, output ready);
endinterface

@@ src/gbsp_out_if.sv @@
// Interface: result channel carrying one parsed event per beat.
interface gbsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] word_value;
  logic [15:0] height;
  logic [7:0]  index_value;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  aspect_ratio;
  logic [3:0]  color_bits;
  logic [3:0]  color_resolution;
  logic [5:0]  flags;
  logic [2:0]  disposal;
  modport source (output valid, kind, word_value, height, index_value, red, green, blue,
                  aspect_ratio, color_bits, color_resolution, flags, disposal,
                  input ready);
  modport sink (input valid, kind, word_value, height, index_value, red, green, blue,
                aspect_ratio, color_bits, color_resolution, flags, disposal,
                output ready);
endinterface

@@ src/gbsp_front.sv @@
// Front: input queue stage that accepts beats and passes resume items through unchanged.
module gbsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gbsp_pkg::item_t     in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output gbsp_pkg::item_t     q_item
);
  import gbsp_pkg::*;

  // Two-entry queue so each side stalls on its own
  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ src/gbsp_back.sv @@
// Back: block parser state machine with registered result stage.
module gbsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  gbsp_pkg::item_t     q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output gbsp_pkg::result_t   out_res
);
  import gbsp_pkg::*;

  localparam logic [3:0] PH_HEADER  = 4'd0;
  localparam logic [3:0] PH_PALETTE = 4'd1;
  localparam logic [3:0] PH_BLOCK   = 4'd2;
  localparam logic [3:0] PH_EXTID   = 4'd3;
  localparam logic [3:0] PH_SUBSIZE = 4'd4;
  localparam logic [3:0] PH_SUBDATA = 4'd5;
  localparam logic [3:0] PH_WAIT    = 4'd6;
  localparam logic [3:0] PH_TERM    = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;
  localparam logic [3:0] PH_HALT    = 4'd9;

  logic [3:0]  phase;
  logic [7:0]  byte_count;
  logic [7:0]  subblock_left;
  logic [7:0]  extension_id;
  logic        first_subblock;
  logic [7:0]  sub_b [4];
  logic        netscape_match;
  logic [15:0] screen_width_reg;
  logic [15:0] screen_height_reg;
  logic [7:0]  packed_fields;
  logic [7:0]  background_reg;
  logic [8:0]  palette_left;
  logic [1:0]  color_part;
  logic [7:0]  partial_rgb [2];
  logic [7:0]  ctl_b [4];
  logic        control_present;
  logic        image_seen;

  logic        step;
  logic        emit;
  result_t     res;
  logic [7:0]  d;
  logic [7:0]  sb [4];
  logic [8:0]  total;
  logic [8:0]  pal_index;
  logic        last_byte;

  // Result register frees when empty or being taken
  assign q_ready   = !out_valid || out_ready;
  assign step      = q_valid && q_ready;
  assign d         = q_item.data_byte;
  assign total     = 9'(10'd2 << packed_fields[2:0]);
  assign pal_index = total - palette_left;
  assign last_byte = (subblock_left == 8'd1);

  // Subblock bytes including the one arriving now
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sb[i] = (byte_count == 8'(i)) ? d : sub_b[i];
    end
  end

  // Event formation for the item at the head of the queue
  always_comb begin
    res  = '0;
    emit = 1'b0;
    if (q_item.op == OP_BYTE) begin
      unique case (phase)
        PH_HEADER: begin
          if (byte_count < 8'd4) begin
            if (d != gif_magic(byte_count[1:0])) begin
              emit = 1'b1;
              res.kind = KIND_ERROR;
            end
          end else if (byte_count == 8'd12) begin
            emit = 1'b1;
            res.kind = KIND_SCREEN;
            res.word_value = screen_width_reg;
            res.height = screen_height_reg;
            res.index_value = background_reg;
            res.aspect_ratio = d;
            res.color_bits = {1'b0, packed_fields[2:0]} + 4'd1;
            res.color_resolution = {1'b0, packed_fields[6:4]} + 4'd1;
            res.flags = {4'b0, packed_fields[7], packed_fields[3]};
          end
        end
        PH_PALETTE: begin
          if (color_part == 2'd2) begin
            emit = 1'b1;
            res.kind = KIND_PALETTE;
            res.index_value = pal_index[7:0];
            res.red = partial_rgb[0];
            res.green = partial_rgb[1];
            res.blue = d;
          end
        end
        PH_BLOCK: begin
          if (d == BLK_TRAILER) begin
            emit = 1'b1;
            res.kind = KIND_TRAILER;
          end else if (d == BLK_IMAGE) begin
            emit = 1'b1;
            res.kind = KIND_IMAGE;
            if (control_present) begin
              res.word_value = {ctl_b[2], ctl_b[1]};
              res.index_value = ctl_b[3];
              res.flags = {1'b1, 1'b0, ctl_b[0][1], ctl_b[0][0], 2'b00};
              res.disposal = ctl_b[0][4:2];
            end
          end else if (d != BLK_EXT) begin
            emit = 1'b1;
            res.kind = KIND_ERROR;
          end
        end
        PH_SUBDATA: begin
          if (last_byte) begin
            if (extension_id == EXT_CONTROL) begin
              emit = 1'b1;
              res.kind = KIND_CONTROL;
              res.word_value = {sb[2], sb[1]};
              res.index_value = sb[3];
              res.flags = {1'b1,
                           sb[0][0] && (!image_seen || sb[0][4:2] == 3'd2),
                           sb[0][1], sb[0][0], 2'b00};
              res.disposal = sb[0][4:2];
            end else if (extension_id == EXT_APP && !first_subblock &&
                         netscape_match && sb[0] == 8'd1) begin
              emit = 1'b1;
              res.kind = KIND_LOOP;
              res.word_value = {sb[2], sb[1]};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) out_res <= res;
  end

  // Parser state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_count <= '0;
      subblock_left <= '0;
      extension_id <= '0;
      first_subblock <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        sub_b[i] <= '0;
        ctl_b[i] <= '0;
      end
      netscape_match <= 1'b0;
      screen_width_reg <= '0;
      screen_height_reg <= '0;
      packed_fields <= '0;
      background_reg <= '0;
      palette_left <= '0;
      color_part <= '0;
      partial_rgb[0] <= '0;
      partial_rgb[1] <= '0;
      control_present <= 1'b0;
      image_seen <= 1'b0;
    end else if (step) begin
      if (q_item.op == OP_RESUME) begin
        if (phase == PH_WAIT) begin
          phase <= PH_TERM;
          control_present <= 1'b0;
        end
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (emit && res.kind == KIND_ERROR) begin
              phase <= PH_HALT;
            end else if (byte_count == 8'd12) begin
              byte_count <= '0;
              if (packed_fields[7]) begin
                palette_left <= total;
                color_part <= '0;
                phase <= PH_PALETTE;
              end else begin
                phase <= PH_BLOCK;
              end
            end else begin
              byte_count <= byte_count + 8'd1;
              if (byte_count == 8'd6) screen_width_reg <= {8'd0, d};
              if (byte_count == 8'd7) screen_width_reg[15:8] <= d;
              if (byte_count == 8'd8) screen_height_reg <= {8'd0, d};
              if (byte_count == 8'd9) screen_height_reg[15:8] <= d;
              if (byte_count == 8'd10) packed_fields <= d;
              if (byte_count == 8'd11) background_reg <= d;
            end
          end
          PH_PALETTE: begin
            if (color_part != 2'd2) begin
              partial_rgb[color_part[0]] <= d;
              color_part <= color_part + 2'd1;
            end else begin
              color_part <= '0;
              palette_left <= palette_left - 9'd1;
              if (palette_left == 9'd1) phase <= PH_BLOCK;
            end
          end
          PH_BLOCK: begin
            if (d == BLK_TRAILER) begin
              phase <= PH_DONE;
            end else if (d == BLK_EXT) begin
              phase <= PH_EXTID;
            end else if (d == BLK_IMAGE) begin
              image_seen <= 1'b1;
              phase <= PH_WAIT;
            end else begin
              phase <= PH_HALT;
            end
          end
          PH_EXTID: begin
            extension_id <= d;
            first_subblock <= 1'b1;
            phase <= PH_SUBSIZE;
          end
          PH_SUBSIZE: begin
            if (d == 8'd0) begin
              phase <= PH_BLOCK;
            end else begin
              subblock_left <= d;
              byte_count <= '0;
              for (int i = 0; i < 4; i++) sub_b[i] <= '0;
              if (first_subblock && extension_id == EXT_APP) netscape_match <= 1'b1;
              phase <= PH_SUBDATA;
            end
          end
          PH_SUBDATA: begin
            if (byte_count < 8'd4) sub_b[byte_count[1:0]] <= d;
            if (byte_count != 8'd255) byte_count <= byte_count + 8'd1;
            subblock_left <= subblock_left - 8'd1;
            if (last_byte) begin
              if (extension_id == EXT_CONTROL) begin
                for (int i = 0; i < 4; i++) ctl_b[i] <= sb[i];
                control_present <= 1'b1;
              end
              // Identifier check: any mismatch, or too short a first block
              if (extension_id == EXT_APP && first_subblock &&
                  (byte_count < 8'd10 ||
                   (byte_count == 8'd10 && d != app_name(4'd10)))) begin
                netscape_match <= 1'b0;
              end
              first_subblock <= 1'b0;
              phase <= PH_SUBSIZE;
            end else if (first_subblock && extension_id == EXT_APP &&
                         byte_count < 8'd11 && d != app_name(byte_count[3:0])) begin
              netscape_match <= 1'b0;
            end
          end
          PH_TERM: phase <= PH_BLOCK;
          default: ;
        endcase
      end
    end
  end
endmodule

@@ src/gif_block_stream_parser.sv @@
// Top level: GIF container parser with decoupled intake and block parser.
// Path: an accepted byte waits in the intake queue, is parsed at its head,
// and its event is held in the output register. Throughput: one beat per
// cycle while the output is not stalled, sustained by the two-entry intake
// queue and the output register. Reset: synchronous rst returns the parser
// to the signature check with empty queue and no pending event.
module gif_block_stream_parser (
  input  logic            clk,
  input  logic            rst,
  gbsp_in_if.sink         in_ch,
  gbsp_out_if.source      out_ch
);
  import gbsp_pkg::*;

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  assign in_item.op        = in_ch.op;
  assign in_item.data_byte = in_ch.data_byte;

  gbsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  gbsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.kind             = res.kind;
  assign out_ch.word_value       = res.word_value;
  assign out_ch.height           = res.height;
  assign out_ch.index_value      = res.index_value;
  assign out_ch.red              = res.red;
  assign out_ch.green            = res.green;
  assign out_ch.blue             = res.blue;
  assign out_ch.aspect_ratio     = res.aspect_ratio;
  assign out_ch.color_bits       = res.color_bits;
  assign out_ch.color_resolution = res.color_resolution;
  assign out_ch.flags            = res.flags;
  assign out_ch.disposal         = res.disposal;
endmodule

@@ tb/sv/gbsp_event_checker.sv @@
// Event checker: predicts parser events from accepted input beats and compares results.
`timescale 1ns / 100ps
module gbsp_event_checker (
  input  logic clk,
  input  logic rst,
  gbsp_in_if   in_ch,
  gbsp_out_if  out_ch,
  output int   fail_count,
  output int   pending
);
  import gbsp_pkg::*;

  typedef enum logic [3:0] {
    ST_HEADER, ST_PALETTE, ST_BLOCK, ST_EXTID, ST_SUBSIZE,
    ST_SUBDATA, ST_WAIT, ST_TERM, ST_DONE, ST_HALT
  } parse_st_t;

  typedef logic [7:0] quad_t [4];

  localparam string MAGIC  = "GIF8";
  localparam string APP_ID = "NETSCAPE2.0";

  // parser state mirror
  parse_st_t   st;
  logic [7:0]  cnt, sub_left, ext_id;
  logic        first_sub, app_match, ctl_valid, image_seen;
  quad_t       sub_bytes, ctl_saved;
  logic [15:0] scr_w, scr_h;
  logic [7:0]  packed_f, bg_index;
  logic [8:0]  pal_left;
  logic [1:0]  rgb_part;
  logic [7:0]  rgb_hold [2];

  result_t expected_events [$];

  assign pending = expected_events.size();

  function automatic void put_control(inout result_t r, input quad_t cb);
    r.word_value  = {cb[2], cb[1]};
    r.index_value = cb[3];
    r.flags       = 6'h20 | (6'(cb[0][0]) << 2) | (6'(cb[0][1]) << 3);
    r.disposal    = cb[0][4:2];
  endfunction

  // End of a sub-block: control event, loop count, or application name check
  function automatic logic close_sub(inout result_t r);
    logic emit;
    emit = 1'b0;
    if (ext_id == EXT_CONTROL) begin
      ctl_saved = sub_bytes;
      ctl_valid = 1'b1;
      r.kind = KIND_CONTROL;
      put_control(r, sub_bytes);
      if (sub_bytes[0][0] && (!image_seen || sub_bytes[0][4:2] == 3'd2))
        r.flags = r.flags | 6'h10;
      emit = 1'b1;
    end else if (ext_id == EXT_APP) begin
      if (first_sub) begin
        if (cnt < 8'd11) app_match = 1'b0;
      end else if (app_match && sub_bytes[0] == 8'd1) begin
        r.kind = KIND_LOOP;
        r.word_value = {sub_bytes[2], sub_bytes[1]};
        emit = 1'b1;
      end
    end
    first_sub = 1'b0;
    st = ST_SUBSIZE;
    return emit;
  endfunction

  function automatic logic predict_event(input logic op, input logic [7:0] d,
                                         output result_t r);
    logic [8:0] total;
    r = '0;
    if (op == OP_RESUME) begin
      if (st == ST_WAIT) begin
        st = ST_TERM;
        ctl_valid = 1'b0;
      end
      return 1'b0;
    end
    case (st)
      ST_HEADER: begin
        if (cnt < 8'd4) begin
          if (d != MAGIC[cnt]) begin
            r.kind = KIND_ERROR;
            st = ST_HALT;
            return 1'b1;
          end
        end else if (cnt == 8'd6) scr_w[7:0] = d;
        else if (cnt == 8'd7) scr_w[15:8] = d;
        else if (cnt == 8'd8) scr_h[7:0] = d;
        else if (cnt == 8'd9) scr_h[15:8] = d;
        else if (cnt == 8'd10) packed_f = d;
        else if (cnt == 8'd11) bg_index = d;
        else if (cnt == 8'd12) begin
          r.kind = KIND_SCREEN;
          r.word_value = scr_w;
          r.height = scr_h;
          r.index_value = bg_index;
          r.aspect_ratio = d;
          r.color_bits = 4'(packed_f[2:0]) + 4'd1;
          r.color_resolution = 4'(packed_f[6:4]) + 4'd1;
          r.flags = {4'b0, packed_f[7], packed_f[3]};
          cnt = 8'd0;
          if (packed_f[7]) begin
            pal_left = 9'd2 << packed_f[2:0];
            rgb_part = 2'd0;
            st = ST_PALETTE;
          end else begin
            st = ST_BLOCK;
          end
          return 1'b1;
        end
        cnt = cnt + 8'd1;
        return 1'b0;
      end
      ST_PALETTE: begin
        if (rgb_part < 2'd2) begin
          rgb_hold[rgb_part[0]] = d;
          rgb_part = rgb_part + 2'd1;
          return 1'b0;
        end
        total = 9'd2 << packed_f[2:0];
        r.kind = KIND_PALETTE;
        r.index_value = 8'(total - pal_left);
        r.red = rgb_hold[0];
        r.green = rgb_hold[1];
        r.blue = d;
        rgb_part = 2'd0;
        pal_left = pal_left - 9'd1;
        if (pal_left == 9'd0) st = ST_BLOCK;
        return 1'b1;
      end
      ST_BLOCK: begin
        if (d == BLK_TRAILER) begin
          r.kind = KIND_TRAILER;
          st = ST_DONE;
          return 1'b1;
        end
        if (d == BLK_EXT) begin
          st = ST_EXTID;
          return 1'b0;
        end
        if (d == BLK_IMAGE) begin
          r.kind = KIND_IMAGE;
          if (ctl_valid) put_control(r, ctl_saved);
          image_seen = 1'b1;
          st = ST_WAIT;
          return 1'b1;
        end
        r.kind = KIND_ERROR;
        st = ST_HALT;
        return 1'b1;
      end
      ST_EXTID: begin
        ext_id = d;
        first_sub = 1'b1;
        st = ST_SUBSIZE;
        return 1'b0;
      end
      ST_SUBSIZE: begin
        if (d == 8'd0) begin
          st = ST_BLOCK;
          return 1'b0;
        end
        sub_left = d;
        cnt = 8'd0;
        sub_bytes = '{default: 8'd0};
        if (first_sub && ext_id == EXT_APP) app_match = 1'b1;
        st = ST_SUBDATA;
        return 1'b0;
      end
      ST_SUBDATA: begin
        if (cnt < 8'd4) sub_bytes[cnt[1:0]] = d;
        if (first_sub && ext_id == EXT_APP && cnt < 8'd11 && d != APP_ID[cnt])
          app_match = 1'b0;
        if (cnt < 8'd255) cnt = cnt + 8'd1;
        sub_left = sub_left - 8'd1;
        if (sub_left == 8'd0) return close_sub(r);
        return 1'b0;
      end
      ST_TERM: begin
        st = ST_BLOCK;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: event mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Result beats are checked before the same edge's input beat is predicted
  always @(posedge clk) begin
    result_t want, got, nxt;
    if (rst) begin
      st = ST_HEADER; cnt = '0; sub_left = '0; ext_id = '0; first_sub = 1'b1;
      sub_bytes = '{default: 8'd0}; ctl_saved = '{default: 8'd0};
      app_match = 1'b0; scr_w = '0; scr_h = '0; packed_f = '0; bg_index = '0;
      pal_left = '0; rgb_part = '0; rgb_hold = '{default: 8'd0};
      ctl_valid = 1'b0; image_seen = 1'b0;
      expected_events.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.word_value, out_ch.height, out_ch.index_value,
                out_ch.red, out_ch.green, out_ch.blue, out_ch.aspect_ratio,
                out_ch.color_bits, out_ch.color_resolution, out_ch.flags,
                out_ch.disposal};
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected beat, kind", 16'(got.kind), 16'hFFFF);
        end else begin
          want = expected_events.pop_front();
          compare_field("kind", 16'(got.kind), 16'(want.kind));
          compare_field("word_value", got.word_value, want.word_value);
          compare_field("height", got.height, want.height);
          compare_field("index_value", 16'(got.index_value), 16'(want.index_value));
          compare_field("red", 16'(got.red), 16'(want.red));
          compare_field("green", 16'(got.green), 16'(want.green));
          compare_field("blue", 16'(got.blue), 16'(want.blue));
          compare_field("aspect_ratio", 16'(got.aspect_ratio), 16'(want.aspect_ratio));
          compare_field("color_bits", 16'(got.color_bits), 16'(want.color_bits));
          compare_field("color_resolution", 16'(got.color_resolution),
                        16'(want.color_resolution));
          compare_field("flags", 16'(got.flags), 16'(want.flags));
          compare_field("disposal", 16'(got.disposal), 16'(want.disposal));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_event(in_ch.op, in_ch.data_byte, nxt)) expected_events.push_back(nxt);
      end
    end
  end

  initial fail_count = 0;

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: drives a GIF byte stream into the parser and gives the verdict.
`timescale 1ns / 100ps
module tb;
  import gbsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, cycles, beats_sent;
  bit   steady_in, steady_out;

  gbsp_in_if  in_ch ();
  gbsp_out_if out_ch ();

  gif_block_stream_parser dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  gbsp_event_checker evt_chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result-side stalls
  always @(negedge clk)
    out_ch.ready <= steady_out || ($urandom_range(99) >= 21);

  // One beat: optional gap, then hold until accepted
  task automatic send_beat(input logic op, input logic [7:0] d);
    if (!steady_in && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.data_byte <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] q [$]);
    foreach (q[i]) send_beat(OP_BYTE, q[i]);
  endtask

  // Graphic control extension with n sub-blocks of given size
  task automatic ctl_ext(input int n, input int sz, input logic [7:0] b0);
    logic [7:0] q [$];
    q = {BLK_EXT, EXT_CONTROL};
    repeat (n) begin
      q.push_back(8'(sz));
      for (int i = 0; i < sz; i++) q.push_back(i == 0 ? b0 : 8'($urandom));
    end
    q.push_back(8'd0);
    send_bytes(q);
  endtask

  // Application extension; id_len/corrupt shape the identifier sub-block
  task automatic app_ext(input int id_len, input bit corrupt, input int loops);
    string      id;
    logic [7:0] q [$];
    id = "NETSCAPE2.0";
    q = {BLK_EXT, EXT_APP, 8'(id_len)};
    for (int i = 0; i < id_len; i++) q.push_back(i < 11 ? id[i] : 8'($urandom));
    if (corrupt) q[2 + $urandom_range(1, id_len)] ^= 8'h01 << $urandom_range(7);
    repeat (loops) begin
      if ($urandom_range(5) == 0) begin
        q.push_back(8'($urandom_range(1, 6)));
        repeat (q[$]) q.push_back(8'($urandom));
      end else begin
        q = {q, 8'd3, 8'd1, 8'($urandom), 8'($urandom)};
      end
    end
    q.push_back(8'd0);
    send_bytes(q);
  endtask

  // Skipped extension with random sub-blocks
  task automatic skip_ext(input logic [7:0] id);
    logic [7:0] q [$];
    q = {BLK_EXT, id};
    repeat ($urandom_range(0, 2)) begin
      q.push_back(8'($urandom_range(1, 20)));
      repeat (q[$]) q.push_back(8'($urandom));
    end
    q.push_back(8'd0);
    send_bytes(q);
  endtask

  // Image: separator, decoder bytes, resume, optional stray resume, terminator
  task automatic image_block();
    send_beat(OP_BYTE, BLK_IMAGE);
    repeat ($urandom_range(0, 5)) send_beat(OP_BYTE, 8'($urandom));
    send_beat(OP_RESUME, 8'($urandom));
    if ($urandom_range(3) == 0) send_beat(OP_RESUME, 8'($urandom));
    send_beat(OP_BYTE, 8'($urandom));
  endtask

  task automatic random_block();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      ctl_ext($urandom_range(3) == 0 ? 2 : 1,
              $urandom_range(3) == 0 ? $urandom_range(1, 7) : 4, 8'($urandom));
    else if (pick < 45)
      app_ext($urandom_range(3) == 0 ? $urandom_range(8, 13) : 11,
              $urandom_range(4) == 0, $urandom_range(0, 2));
    else if (pick < 60)
      skip_ext($urandom_range(1) ? 8'hFE : 8'($urandom));
    else if (pick < 90)
      image_block();
    else
      send_beat(OP_RESUME, 8'($urandom));
  endtask

  initial begin
    logic [7:0] hdr [$];
    logic [7:0] pk, bad;
    bit         drained;
    cycles = 0;
    beats_sent = 0;
    drained = 1'b0;
    steady_in = 1'b0;
    steady_out = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_BYTE;
    in_ch.data_byte = 8'd0;
    out_ch.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Header: stray resume first, then signature and screen descriptor
    send_beat(OP_RESUME, 8'hFF);
    pk = {1'b1, 3'($urandom), 1'($urandom), 3'($urandom_range(2))};
    hdr = {"G", "I", "F", "8", "9", "a", 8'hFF, 8'hFF, 8'h00, 8'h00, pk,
           8'($urandom), 8'($urandom)};
    send_bytes(hdr);
    // Global palette
    repeat (3 * (1 << (pk[2:0] + 1))) send_beat(OP_BYTE, 8'($urandom));

    // Directed blocks
    image_block();
    ctl_ext(1, 4, 8'b0000_1001);
    ctl_ext(2, 4, 8'hFF);
    image_block();
    ctl_ext(1, 4, 8'b0000_1001);
    ctl_ext(1, 1, 8'b0000_0101);
    ctl_ext(1, 6, 8'h1F);
    image_block();
    image_block();
    app_ext(11, 1'b0, 2);
    app_ext(9, 1'b0, 1);
    app_ext(11, 1'b1, 1);
    skip_ext(8'hFE);
    skip_ext(8'h01);

    // Random blocks; one stretch without stalls, one full drain pause
    while (beats_sent < 500) begin
      steady_in = (beats_sent > 250 && beats_sent < 350);
      steady_out = steady_in;
      random_block();
      if (!drained && beats_sent > 400) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    steady_in = 1'b0;
    steady_out = 1'b0;

    // End of stream: trailer or unknown block byte, then ignored beats
    if ($urandom_range(3) == 0) begin
      do bad = 8'($urandom); while (bad == BLK_EXT || bad == BLK_IMAGE || bad == BLK_TRAILER);
      send_beat(OP_BYTE, bad);
    end else begin
      send_beat(OP_BYTE, BLK_TRAILER);
    end
    repeat (6) send_beat(1'($urandom), 8'($urandom));
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/gbsp_pkg.sv
src/gbsp_in_if.sv
src/gbsp_out_if.sv
src/gbsp_front.sv
src/gbsp_back.sv
src/gif_block_stream_parser.sv
tb/sv/gbsp_event_checker.sv
tb/sv/tb.sv
